// ===== sv/srd_pkg.sv =====
package srd_pkg;

    localparam int ROW_W      = 12;
    localparam int IN_INT_W   = 16;
    localparam int OUT_IDX_W  = 10;
    localparam int MEAN_W     = 16;
    localparam int SAT_W      = 16;
    localparam int HOLE_W     = 12;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SAT_LEVEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLE_SIZE = 2'd1;

    typedef struct packed {
        logic [SAT_W-1:0]  sat_level;
        logic [HOLE_W-1:0] hole_size;
    } cfg_t;

    typedef struct packed {
        logic push0;
        logic push1;
    } push_t;

endpackage

// ===== sv/srd_front.sv =====
module srd_front
    import srd_pkg::*;
#(
    parameter int IDX_W = 10,
    parameter int IW    = 16,
    parameter int SUM_W = 27,
    parameter int E_W   = 48,
    parameter int LAST_IDX = 1023
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [ROW_W-1:0]    row,
    input  logic [IN_INT_W-1:0] intensity,
    input  logic                last_point,
    input  logic                q_room2,
    output push_t               push,
    output logic [E_W-1:0]      word0,
    output logic [E_W-1:0]      word1
);

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             pv_reg, pv_next;
    logic             in_run_reg, in_run_next;
    logic [IDX_W-1:0] ps_reg, ps_next;
    logic [IDX_W-1:0] pe_reg, pe_next;
    logic [ROW_W-1:0] per_reg, per_next;
    logic [SUM_W-1:0] psum_reg, psum_next;
    logic [SUM_W-1:0] rsum_reg, rsum_next;

    logic             accept;
    logic [IW-1:0]    inten;
    logic             sat;
    logic             last;
    logic [ROW_W-1:0] gap;
    logic             merge;
    logic             emit_a;
    logic             emit_b;
    logic [E_W-1:0]   word_a;
    logic [E_W-1:0]   word_b;

    assign in_ready = q_room2;
    assign accept   = in_valid && q_room2;
    assign inten    = intensity[IW-1:0];
    assign sat      = SAT_W'(inten) >= cfg.sat_level;
    assign last     = last_point || (idx_reg == IDX_W'(LAST_IDX));
    assign gap      = (row > per_reg) ? (row - per_reg) : '0;
    assign merge    = pv_reg && (cfg.hole_size != '0) && (gap < cfg.hole_size);

    always_comb
    begin
        idx_next    = idx_reg;
        pv_next     = pv_reg;
        in_run_next = in_run_reg;
        ps_next     = ps_reg;
        pe_next     = pe_reg;
        per_next    = per_reg;
        psum_next   = psum_reg;
        rsum_next   = rsum_reg;
        emit_a      = 1'b0;
        emit_b      = 1'b0;
        if (accept)
        begin
            if (sat)
            begin
                if (in_run_reg)
                begin
                    psum_next = psum_reg + SUM_W'(inten);
                end
                else if (merge)
                begin
                    psum_next = psum_reg + rsum_reg + SUM_W'(inten);
                end
                else
                begin
                    emit_a    = pv_reg;
                    ps_next   = idx_reg;
                    psum_next = SUM_W'(inten);
                    pv_next   = 1'b1;
                end
                pe_next     = idx_reg;
                per_next    = row;
                in_run_next = 1'b1;
                rsum_next   = '0;
            end
            else
            begin
                in_run_next = 1'b0;
                rsum_next   = rsum_reg + SUM_W'(inten);
            end
            emit_b = last && pv_next;
        end
        word_a = {!emit_b, psum_reg, pe_reg, ps_reg};
        word_b = {1'b1, psum_next, pe_next, ps_next};
        if (accept)
        begin
            if (last)
            begin
                idx_next    = '0;
                pv_next     = 1'b0;
                in_run_next = 1'b0;
                ps_next     = '0;
                pe_next     = '0;
                per_next    = '0;
                psum_next   = '0;
                rsum_next   = '0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    assign push.push0 = emit_a || emit_b;
    assign push.push1 = emit_a && emit_b;
    assign word0      = emit_a ? word_a : word_b;
    assign word1      = word_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            pv_reg     <= 1'b0;
            in_run_reg <= 1'b0;
            ps_reg     <= '0;
            pe_reg     <= '0;
            per_reg    <= '0;
            psum_reg   <= '0;
            rsum_reg   <= '0;
        end
        else
        begin
            idx_reg    <= idx_next;
            pv_reg     <= pv_next;
            in_run_reg <= in_run_next;
            ps_reg     <= ps_next;
            pe_reg     <= pe_next;
            per_reg    <= per_next;
            psum_reg   <= psum_next;
            rsum_reg   <= rsum_next;
        end
    end

endmodule

// ===== sv/srd_queue.sv =====
module srd_queue
    import srd_pkg::*;
#(
    parameter int E_W = 48
) (
    input  logic           clk,
    input  logic           rst_n,
    input  push_t          push,
    input  logic [E_W-1:0] din0,
    input  logic [E_W-1:0] din1,
    output logic           room2,
    input  logic           pop,
    output logic           valid,
    output logic [E_W-1:0] dout
);

    logic [E_W-1:0]   mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wptr_reg, wptr_next;
    logic [Q_PTR_W-1:0] rptr_reg, rptr_next;
    logic [Q_PTR_W:0]   cnt_reg, cnt_next;
    logic [Q_PTR_W:0]   n_push;
    logic [Q_PTR_W-1:0] wptr_plus1;

    assign valid      = cnt_reg != '0;
    assign room2      = cnt_reg <= (Q_PTR_W+1)'(Q_DEPTH - 2);
    assign dout       = mem[rptr_reg];
    assign wptr_plus1 = wptr_reg + 1'b1;
    assign n_push     = (Q_PTR_W+1)'(push.push0) + (Q_PTR_W+1)'(push.push1);

    always_comb
    begin
        wptr_next = wptr_reg + n_push[Q_PTR_W-1:0];
        rptr_next = rptr_reg + (Q_PTR_W)'(pop && valid);
        cnt_next  = cnt_reg + n_push - (Q_PTR_W+1)'(pop && valid);
    end

    always_ff @(posedge clk)
    begin
        if (push.push0)
        begin
            mem[wptr_reg] <= din0;
        end
        if (push.push1)
        begin
            mem[wptr_plus1] <= din1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// ===== sv/srd_back.sv =====
module srd_back
    import srd_pkg::*;
#(
    parameter int IDX_W = 10,
    parameter int SUM_W = 27,
    parameter int E_W   = 48
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  logic [E_W-1:0]       q_data,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [OUT_IDX_W-1:0] start_index,
    output logic [OUT_IDX_W-1:0] end_index,
    output logic [MEAN_W-1:0]    run_mean,
    output logic                 last_result
);

    localparam int DV_W  = IDX_W + 1;
    localparam int CNT_W = $clog2(SUM_W + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0] quo_reg, quo_next;
    logic [DV_W-1:0]  rem_reg, rem_next;
    logic [DV_W-1:0]  div_reg, div_next;
    logic [IDX_W-1:0] st_reg, st_next;
    logic [IDX_W-1:0] en_reg, en_next;
    logic             lst_reg, lst_next;

    logic             ov_reg, ov_next;
    logic [OUT_IDX_W-1:0] os_reg, os_next;
    logic [OUT_IDX_W-1:0] oe_reg, oe_next;
    logic [MEAN_W-1:0]    om_reg, om_next;
    logic                 ol_reg, ol_next;

    logic [IDX_W-1:0] q_start;
    logic [IDX_W-1:0] q_end;
    logic [SUM_W-1:0] q_sum;
    logic             q_last;
    logic [DV_W:0]    rem_sh;
    logic [DV_W:0]    diff;
    logic             load_out;

    assign q_start = q_data[IDX_W-1:0];
    assign q_end   = q_data[2*IDX_W-1:IDX_W];
    assign q_sum   = q_data[2*IDX_W+SUM_W-1:2*IDX_W];
    assign q_last  = q_data[2*IDX_W+SUM_W];
    assign rem_sh  = {rem_reg, quo_reg[SUM_W-1]};
    assign diff    = rem_sh - {1'b0, div_reg};
    assign q_pop   = (state_reg == ST_IDLE) && q_valid;
    assign load_out = (state_reg == ST_DONE) && (!ov_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        st_next    = st_reg;
        en_next    = en_reg;
        lst_next   = lst_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    quo_next   = q_sum;
                    rem_next   = '0;
                    div_next   = DV_W'(q_end) - DV_W'(q_start) + 1'b1;
                    st_next    = q_start;
                    en_next    = q_end;
                    lst_next   = q_last;
                    cnt_next   = CNT_W'(SUM_W);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!diff[DV_W])
                begin
                    rem_next = diff[DV_W-1:0];
                    quo_next = {quo_reg[SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[DV_W-1:0];
                    quo_next = {quo_reg[SUM_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ov_next = ov_reg;
        os_next = os_reg;
        oe_next = oe_reg;
        om_next = om_reg;
        ol_next = ol_reg;
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        if (load_out)
        begin
            ov_next = 1'b1;
            os_next = OUT_IDX_W'(st_reg);
            oe_next = OUT_IDX_W'(en_reg);
            om_next = MEAN_W'(quo_reg);
            ol_next = lst_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        st_reg  <= st_next;
        en_reg  <= en_next;
        lst_reg <= lst_next;
        os_reg  <= os_next;
        oe_reg  <= oe_next;
        om_reg  <= om_next;
        ol_reg  <= ol_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    assign out_valid   = ov_reg;
    assign start_index = os_reg;
    assign end_index   = oe_reg;
    assign run_mean    = om_reg;
    assign last_result = ol_reg;

endmodule

// ===== sv/saturated_run_detector_top.sv =====
// A run word enters the queue when the point closing it is accepted; the divider pops it
// when idle (sum width SUM_W = min(INTENSITY_BITS,16) + clog2(MAX_POINTS) + 1, 27 by default).
// Throughput: one point per cycle while the four-word run queue has two free slots;
// the bit-serial mean divider takes a new run word only once it has passed the last one to the output register.
// Reset: asynchronous, active low; clears run tracking, the queue and the divider,
// and sets saturation_level to 65535 and hole_size to 0.
module saturated_run_detector_top
    import srd_pkg::*;
#(
    parameter int MAX_POINTS     = 1024,
    parameter int INTENSITY_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // row[11:0], intensity[27:12], zero[31:28]
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,  // start_index[9:0], end_index[19:10],
                                                 // run_mean[35:20], zero[39:36]
    output logic                  m_axis_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W    = $clog2(MAX_POINTS);
    localparam int IW       = (INTENSITY_BITS < IN_INT_W) ? INTENSITY_BITS : IN_INT_W;
    localparam int SUM_W    = IW + IDX_W + 1;
    localparam int E_W      = 1 + SUM_W + 2 * IDX_W;
    localparam int LAST_IDX = MAX_POINTS - 1;

    cfg_t cfg_reg, cfg_next;

    push_t          push;
    logic [E_W-1:0] word0;
    logic [E_W-1:0] word1;
    logic           q_room2;
    logic           q_pop;
    logic           q_valid;
    logic [E_W-1:0] q_data;

    logic [OUT_IDX_W-1:0] start_index;
    logic [OUT_IDX_W-1:0] end_index;
    logic [MEAN_W-1:0]    run_mean;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_SAT_LEVEL: cfg_next.sat_level = cfg_data[SAT_W-1:0];
                REG_HOLE_SIZE: cfg_next.hole_size = cfg_data[HOLE_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sat_level <= '1;
            cfg_reg.hole_size <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    srd_front #(
        .IDX_W    (IDX_W),
        .IW       (IW),
        .SUM_W    (SUM_W),
        .E_W      (E_W),
        .LAST_IDX (LAST_IDX)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .row        (s_axis_tdata[ROW_W-1:0]),
        .intensity  (s_axis_tdata[ROW_W+IN_INT_W-1:ROW_W]),
        .last_point (s_axis_tlast),
        .q_room2    (q_room2),
        .push       (push),
        .word0      (word0),
        .word1      (word1)
    );

    srd_queue #(
        .E_W (E_W)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din0  (word0),
        .din1  (word1),
        .room2 (q_room2),
        .pop   (q_pop),
        .valid (q_valid),
        .dout  (q_data)
    );

    srd_back #(
        .IDX_W (IDX_W),
        .SUM_W (SUM_W),
        .E_W   (E_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .start_index (start_index),
        .end_index   (end_index),
        .run_mean    (run_mean),
        .last_result (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, run_mean, end_index, start_index};

endmodule

// ===== tb/sv/saturated_run_detector_top_tb.sv =====
module saturated_run_detector_top_tb;
    import srd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 8;
    localparam int POINT_LIMIT    = 1024;
    localparam int DRAIN_CYCLES   = 48;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 1200;
    localparam int NO_IDLE_ITEMS  = 100;
    localparam int PHASE_ITEMS    = 20;
    localparam int REPORT_LIMIT   = 10;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] start_idx;
        logic [OUT_IDX_W-1:0] end_idx;
        logic [MEAN_W-1:0]    mean_val;
        logic                 is_last;
    } run_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    saturated_run_detector_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // run tracker copy
    logic [SAT_W-1:0]     sat_level;
    logic [HOLE_W-1:0]    hole_size;
    logic [OUT_IDX_W-1:0] point_idx;
    logic                 pend_valid;
    logic                 in_run;
    logic [OUT_IDX_W-1:0] pend_start;
    logic [OUT_IDX_W-1:0] pend_end;
    logic [ROW_W-1:0]     pend_end_row;
    logic [31:0]          pend_sum;
    logic [31:0]          gap_sum;

    run_word_t runs_q[$];
    run_word_t got_run;
    run_word_t want_run;

    int  mismatches  = 0;
    int  items_sent  = 0;
    int  idle_cycles = 0;
    bit  s_gaps      = 1'b1;
    bit  m_gaps      = 1'b1;

    task automatic clear_tracker();
        point_idx    = '0;
        pend_valid   = 1'b0;
        in_run       = 1'b0;
        pend_start   = '0;
        pend_end     = '0;
        pend_end_row = '0;
        pend_sum     = '0;
        gap_sum      = '0;
    endtask

    function automatic run_word_t close_run();
        run_word_t  r;
        logic [10:0] cnt;
        logic [31:0] q;
        cnt = {1'b0, pend_end} - {1'b0, pend_start} + 11'd1;
        q = pend_sum / 32'(cnt);
        r.start_idx = pend_start;
        r.end_idx   = pend_end;
        r.mean_val  = q[MEAN_W-1:0];
        r.is_last   = 1'b0;
        return r;
    endfunction

    task automatic track_point(input logic [ROW_W-1:0] row, input logic [IN_INT_W-1:0] inten,
                               input logic last_in);
        run_word_t        done[2];
        int               n;
        logic [OUT_IDX_W-1:0] idx;
        logic             closing;
        logic [ROW_W-1:0] gap;
        logic             merged;
        n = 0;
        idx = point_idx;
        closing = last_in || (int'(idx) >= POINT_LIMIT - 1);
        if (inten >= sat_level) begin
            if (in_run) begin
                pend_end     = idx;
                pend_end_row = row;
                pend_sum     = pend_sum + 32'(inten);
            end else begin
                gap = (row > pend_end_row) ? row - pend_end_row : '0;
                merged = pend_valid && hole_size != '0 && gap < hole_size;
                if (merged) begin
                    pend_sum = pend_sum + gap_sum + 32'(inten);
                end else begin
                    if (pend_valid) begin
                        done[n] = close_run();
                        n++;
                    end
                    pend_start = idx;
                    pend_sum   = 32'(inten);
                    pend_valid = 1'b1;
                end
                pend_end     = idx;
                pend_end_row = row;
                in_run       = 1'b1;
            end
            gap_sum = '0;
        end else begin
            in_run  = 1'b0;
            gap_sum = gap_sum + 32'(inten);
        end
        if (closing) begin
            if (pend_valid) begin
                done[n] = close_run();
                n++;
            end
            clear_tracker();
        end else begin
            point_idx = idx + 1'b1;
        end
        if (n > 0)
            done[n-1].is_last = 1'b1;
        for (int i = 0; i < n; i++)
            runs_q.push_back(done[i]);
    endtask

    task automatic send_point(input logic [ROW_W-1:0] row, input logic [IN_INT_W-1:0] inten,
                              input logic last_in);
        int hold;
        if (s_gaps && $urandom_range(99, 0) < 25) begin
            s_axis_tvalid <= 1'b0;
            hold = $urandom_range(2, 1);
            repeat (hold) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W - ROW_W - IN_INT_W){1'b0}}, inten, row};
        s_axis_tlast  <= last_in;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        track_point(row, inten, last_in);
        items_sent++;
    endtask

    // hold off until every run word is back and the pipeline is empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (runs_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            REG_SAT_LEVEL: sat_level = data[SAT_W-1:0];
            REG_HOLE_SIZE: hole_size = data[HOLE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] sat, input logic [CFG_DATA_W-1:0] hole);
        settle();
        write_reg(REG_SAT_LEVEL, sat);
        write_reg(REG_HOLE_SIZE, hole);
        write_reg(($urandom_range(1, 0) == 0) ? REG_SPARE_2 : REG_SPARE_3,
                  CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [IN_INT_W-1:0] pick_intensity(input bit hot);
        if (hot)
            return IN_INT_W'(int'(sat_level) + $urandom_range(65535 - int'(sat_level), 0));
        if (sat_level == '0)
            return IN_INT_W'($urandom);
        return IN_INT_W'($urandom_range(int'(sat_level) - 1, 0));
    endfunction

    task automatic send_sequence(input int len, input bit noisy);
        logic [ROW_W-1:0]    row;
        logic [IN_INT_W-1:0] inten;
        logic                last_in;
        bit                  hot;
        int                  stretch;
        row = ROW_W'($urandom);
        hot = 1'($urandom_range(1, 0));
        stretch = $urandom_range(6, 1);
        for (int i = 0; i < len; i++) begin
            if (noisy) begin
                row     = ROW_W'($urandom);
                inten   = IN_INT_W'($urandom);
                last_in = (i == len - 1) || ($urandom_range(9, 0) == 0);
            end else begin
                if ($urandom_range(9, 0) == 0)
                    row = row + ROW_W'($urandom_range(40, 0));
                else
                    row = row + ROW_W'($urandom_range(3, 1));
                inten   = pick_intensity(hot);
                last_in = (i == len - 1);
                stretch--;
                if (stretch == 0) begin
                    hot = !hot;
                    stretch = $urandom_range(6, 1);
                end
            end
            send_point(row, inten, last_in);
        end
    endtask

    task automatic test_reset_values();
        send_point(12'd10, 16'd65535, 1'b0);
        send_point(12'd11, 16'd65534, 1'b0);
        send_point(12'd12, 16'd65535, 1'b1);
        send_point(12'd0, 16'd0, 1'b1);
        send_point(12'd4095, 16'd65535, 1'b1);
    endtask

    task automatic test_field_extremes();
        configure(16'd0, 16'd4095);
        send_point(12'd0, 16'd0, 1'b0);
        send_point(12'd4095, 16'd65535, 1'b0);
        send_point(12'd0, 16'd0, 1'b1);
        configure(16'd65535, 16'hF001);
        send_point(12'd4095, 16'd65535, 1'b1);
        send_point(12'd4095, 16'd65534, 1'b1);
    endtask

    task automatic test_hole_merge();
        configure(16'd1000, 16'd5);
        send_point(12'd100, 16'd2000, 1'b0);
        send_point(12'd101, 16'd500, 1'b0);
        send_point(12'd104, 16'd1000, 1'b0);
        send_point(12'd105, 16'd999, 1'b0);
        send_point(12'd110, 16'd3000, 1'b0);
        send_point(12'd111, 16'd10, 1'b0);
        send_point(12'd109, 16'd1500, 1'b0);
        send_point(12'd120, 16'd1, 1'b0);
        send_point(12'd125, 16'd1200, 1'b1);
        configure(16'd1000, 16'd0);
        send_point(12'd1, 16'd1001, 1'b0);
        send_point(12'd2, 16'd0, 1'b0);
        send_point(12'd3, 16'd1000, 1'b1);
    endtask

    task automatic test_ignored_writes();
        settle();
        write_reg(REG_SPARE_2, 16'h0000);
        write_reg(REG_SPARE_3, 16'hFFFF);
        cfg_valid <= 1'b0;
        send_point(12'd7, 16'd1000, 1'b0);
        send_point(12'd8, 16'd999, 1'b0);
        send_point(12'd9, 16'd1000, 1'b1);
    endtask

    task automatic test_long_sequence();
        configure(16'd0, 16'd0);
        send_sequence(POINT_LIMIT + 6, 1'b0);
    endtask

    task automatic test_no_idle_stretch();
        int goal;
        goal = items_sent + NO_IDLE_ITEMS;
        configure(16'd12345, 16'd2);
        s_gaps = 1'b0;
        m_gaps = 1'b0;
        while (items_sent < goal)
            send_sequence($urandom_range(30, 1), $urandom_range(4, 0) == 0);
        settle();
        s_gaps = 1'b1;
        m_gaps = 1'b1;
    endtask

    task automatic test_random_stream();
        int goal;
        goal = RANDOM_ITEMS;
        for (int phase = 0; items_sent < goal; phase++) begin
            case (phase % 6)
                0: configure(16'd32768, 16'd4);
                1: configure(16'd1, 16'd1);
                2: configure(16'd65535, 16'd4095);
                3: configure(16'd0, 16'd0);
                default: configure(CFG_DATA_W'($urandom),
                                   {4'($urandom), 12'($urandom_range(16, 0))});
            endcase
            for (int k = 0; k < PHASE_ITEMS && items_sent < goal; ) begin
                int len;
                len = $urandom_range(12, 1);
                send_sequence(len, $urandom_range(4, 0) == 0);
                k += len;
            end
        end
    endtask

    always @(posedge clk)
        m_axis_tready <= !m_gaps || ($urandom_range(99, 0) >= 25);

    always @(posedge clk) begin
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got_run.start_idx = m_axis_tdata[9:0];
            got_run.end_idx   = m_axis_tdata[19:10];
            got_run.mean_val  = m_axis_tdata[35:20];
            got_run.is_last   = m_axis_tlast;
            if (runs_q.size() == 0) begin
                if (mismatches < REPORT_LIMIT)
                    $display("unexpected run word: start %0d end %0d mean %0d last %0b",
                             got_run.start_idx, got_run.end_idx, got_run.mean_val,
                             got_run.is_last);
                mismatches++;
            end else begin
                want_run = runs_q.pop_front();
                if (got_run !== want_run) begin
                    if (mismatches < REPORT_LIMIT)
                        $display("run word mismatch: expected start %0d end %0d mean %0d last %0b, got start %0d end %0d mean %0d last %0b",
                                 want_run.start_idx, want_run.end_idx, want_run.mean_val,
                                 want_run.is_last, got_run.start_idx, got_run.end_idx,
                                 got_run.mean_val, got_run.is_last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        m_axis_tready <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        sat_level = 16'd65535;
        hole_size = '0;
        clear_tracker();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_field_extremes();
        test_hole_merge();
        test_ignored_writes();
        test_long_sequence();
        test_no_idle_stretch();
        test_random_stream();

        settle();
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/srd_pkg.sv
sv/srd_front.sv
sv/srd_queue.sv
sv/srd_back.sv
sv/saturated_run_detector_top.sv
tb/sv/saturated_run_detector_top_tb.sv
